// File: sv/omw_pkg.sv
package omw_pkg;

	localparam int WHEEL_COUNT    = 4;
	localparam int COS_FRAC_BITS  = 15;
	localparam int NUM_ANGLE_REGS = 4;

	localparam int ANGLE_W = 9;
	localparam int SPD_W   = 12;
	localparam int WI_W    = 2;
	localparam int CNT_W   = (WHEEL_COUNT > 2) ? 2 : 1;
	localparam int CFG_W   = 2;
	localparam int IDX_W   = 7;
	localparam int DUTY_W  = 8;

	// cosine magnitude at COS_FRAC_BITS fraction bits
	localparam int COS_W   = COS_FRAC_BITS + 1;
	localparam int COS_SHL = (COS_FRAC_BITS >= 15) ? COS_FRAC_BITS - 15 : 0;
	localparam int COS_SHR = (COS_FRAC_BITS < 15) ? 15 - COS_FRAC_BITS : 0;
	localparam int COS_RND = (COS_SHR > 0) ? (1 << (COS_SHR - 1)) : 0;

	// product rounded back to 8 fraction bits
	localparam int PROD_W   = COS_W + SPD_W;
	localparam int PROD_SH  = COS_FRAC_BITS - 8;
	localparam int PROD_RND = (PROD_SH > 0) ? (1 << (PROD_SH - 1)) : 0;

	localparam int VAL_W = 22;
	localparam int MAG_W = 21;
	localparam int NUM_W = MAG_W + 9;
	localparam int DEN_W = MAG_W + 1;

	localparam int DUTY_LIMIT = 255 * 256;
	localparam int DUTY_SCALE = 510;

	localparam logic [ANGLE_W-1:0] ANGLE_RST_0 = ANGLE_W'(45);
	localparam logic [ANGLE_W-1:0] ANGLE_RST_1 = ANGLE_W'(135);
	localparam logic [ANGLE_W-1:0] ANGLE_RST_2 = ANGLE_W'(225);
	localparam logic [ANGLE_W-1:0] ANGLE_RST_3 = ANGLE_W'(315);

	typedef enum logic [CFG_W-1:0] {
		CFG_WHEEL_ANGLE_0 = 2'd0,
		CFG_WHEEL_ANGLE_1 = 2'd1,
		CFG_WHEEL_ANGLE_2 = 2'd2,
		CFG_WHEEL_ANGLE_3 = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [WHEEL_COUNT-1:0][COS_W-1:0] cmag;
		logic [WHEEL_COUNT-1:0]            cneg;
		logic [SPD_W-1:0]                  spd_mag;
		logic                              spd_neg;
		logic [SPD_W-1:0]                  corr;
	} cos_cmd_t;

	typedef struct packed {
		logic [WHEEL_COUNT-1:0][MAG_W-1:0] mag;
		logic [WHEEL_COUNT-1:0]            fwd;
		logic [WHEEL_COUNT-1:0]            rev;
		logic [MAG_W-1:0]                  largest;
		logic                              scale;
	} mix_t;

	typedef struct packed {
		logic [DUTY_W-1:0] direct;
		logic              scale;
		logic              fwd;
		logic              rev;
		logic [WI_W-1:0]   idx;
		logic              last;
	} div_tag_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		div_tag_t         tag;
	} div_in_t;

	typedef struct packed {
		logic [WI_W-1:0]   idx;
		logic [DUTY_W-1:0] duty;
		logic              fwd;
		logic              rev;
		logic              last;
	} res_t;

	// quarter-wave cosine, Q1.15; entries past 90 degrees read as zero
	function automatic logic [15:0] cos_quarter(input logic [IDX_W-1:0] idx);
		logic [15:0] r;
		case (idx)
			7'd0: r = 16'd32768;  7'd1: r = 16'd32763;  7'd2: r = 16'd32748;
			7'd3: r = 16'd32723;  7'd4: r = 16'd32688;  7'd5: r = 16'd32643;
			7'd6: r = 16'd32588;  7'd7: r = 16'd32524;  7'd8: r = 16'd32449;
			7'd9: r = 16'd32365;  7'd10: r = 16'd32270; 7'd11: r = 16'd32166;
			7'd12: r = 16'd32052; 7'd13: r = 16'd31928; 7'd14: r = 16'd31795;
			7'd15: r = 16'd31651; 7'd16: r = 16'd31499; 7'd17: r = 16'd31336;
			7'd18: r = 16'd31164; 7'd19: r = 16'd30983; 7'd20: r = 16'd30792;
			7'd21: r = 16'd30592; 7'd22: r = 16'd30382; 7'd23: r = 16'd30163;
			7'd24: r = 16'd29935; 7'd25: r = 16'd29698; 7'd26: r = 16'd29452;
			7'd27: r = 16'd29197; 7'd28: r = 16'd28932; 7'd29: r = 16'd28660;
			7'd30: r = 16'd28378; 7'd31: r = 16'd28088; 7'd32: r = 16'd27789;
			7'd33: r = 16'd27482; 7'd34: r = 16'd27166; 7'd35: r = 16'd26842;
			7'd36: r = 16'd26510; 7'd37: r = 16'd26170; 7'd38: r = 16'd25822;
			7'd39: r = 16'd25466; 7'd40: r = 16'd25102; 7'd41: r = 16'd24730;
			7'd42: r = 16'd24351; 7'd43: r = 16'd23965; 7'd44: r = 16'd23571;
			7'd45: r = 16'd23170; 7'd46: r = 16'd22763; 7'd47: r = 16'd22348;
			7'd48: r = 16'd21926; 7'd49: r = 16'd21498; 7'd50: r = 16'd21063;
			7'd51: r = 16'd20622; 7'd52: r = 16'd20174; 7'd53: r = 16'd19720;
			7'd54: r = 16'd19261; 7'd55: r = 16'd18795; 7'd56: r = 16'd18324;
			7'd57: r = 16'd17847; 7'd58: r = 16'd17364; 7'd59: r = 16'd16877;
			7'd60: r = 16'd16384; 7'd61: r = 16'd15886; 7'd62: r = 16'd15384;
			7'd63: r = 16'd14876; 7'd64: r = 16'd14365; 7'd65: r = 16'd13848;
			7'd66: r = 16'd13328; 7'd67: r = 16'd12803; 7'd68: r = 16'd12275;
			7'd69: r = 16'd11743; 7'd70: r = 16'd11207; 7'd71: r = 16'd10668;
			7'd72: r = 16'd10126; 7'd73: r = 16'd9580;  7'd74: r = 16'd9032;
			7'd75: r = 16'd8481;  7'd76: r = 16'd7927;  7'd77: r = 16'd7371;
			7'd78: r = 16'd6813;  7'd79: r = 16'd6252;  7'd80: r = 16'd5690;
			7'd81: r = 16'd5126;  7'd82: r = 16'd4560;  7'd83: r = 16'd3993;
			7'd84: r = 16'd3425;  7'd85: r = 16'd2856;  7'd86: r = 16'd2286;
			7'd87: r = 16'd1715;  7'd88: r = 16'd1144;  7'd89: r = 16'd572;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// rescale a Q1.15 table entry to COS_FRAC_BITS fraction bits
	function automatic logic [COS_W-1:0] cos_scale(input logic [15:0] m);
		logic [32:0] t;
		t = 33'(m) << COS_SHL;
		t = (t + 33'(COS_RND)) >> COS_SHR;
		return COS_W'(t);
	endfunction

endpackage

// File: sv/omw_angle_cos.sv
module omw_angle_cos
	import omw_pkg::*;
(
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [SPD_W-1:0]             speed,
	input  logic [ANGLE_W-1:0]                  heading,
	input  logic signed [SPD_W-1:0]             correction,
	input  logic [WHEEL_COUNT-1:0][ANGLE_W-1:0] angle,
	output logic                                out_valid,
	output cos_cmd_t                            out_cmd
);

	logic                              valid_s1;
	logic [WHEEL_COUNT-1:0][IDX_W-1:0] idx_s1;
	logic [WHEEL_COUNT-1:0]            neg_s1;
	logic [SPD_W-1:0]                  spd_mag_s1;
	logic                              spd_neg_s1;
	logic [SPD_W-1:0]                  corr_s1;

	logic [WHEEL_COUNT-1:0][IDX_W-1:0] idx_d;
	logic [WHEEL_COUNT-1:0]            neg_d;

	// reduce heading + angle modulo 360 and fold into the first quadrant
	always_comb begin
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			logic [ANGLE_W:0] sum;
			logic [ANGLE_W:0] deg;
			sum = {1'b0, heading} + {1'b0, angle[w]};
			if (sum >= (ANGLE_W+1)'(720)) deg = sum - (ANGLE_W+1)'(720);
			else if (sum >= (ANGLE_W+1)'(360)) deg = sum - (ANGLE_W+1)'(360);
			else deg = sum;
			if (deg <= (ANGLE_W+1)'(90)) begin
				idx_d[w] = IDX_W'(deg);
				neg_d[w] = 1'b0;
			end else if (deg <= (ANGLE_W+1)'(180)) begin
				idx_d[w] = IDX_W'((ANGLE_W+1)'(180) - deg);
				neg_d[w] = 1'b1;
			end else if (deg <= (ANGLE_W+1)'(270)) begin
				idx_d[w] = IDX_W'(deg - (ANGLE_W+1)'(180));
				neg_d[w] = 1'b1;
			end else begin
				idx_d[w] = IDX_W'((ANGLE_W+1)'(360) - deg);
				neg_d[w] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1     <= idx_d;
		neg_s1     <= neg_d;
		spd_mag_s1 <= speed[SPD_W-1] ? SPD_W'(-speed) : SPD_W'(speed);
		spd_neg_s1 <= speed[SPD_W-1];
		corr_s1    <= correction;
	end

	// look up the cosine magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			out_cmd.cmag[w] <= cos_scale(cos_quarter(idx_s1[w]));
		end
		out_cmd.cneg    <= neg_s1;
		out_cmd.spd_mag <= spd_mag_s1;
		out_cmd.spd_neg <= spd_neg_s1;
		out_cmd.corr    <= corr_s1;
	end

endmodule

// File: sv/omw_wheel_calc.sv
module omw_wheel_calc
	import omw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  cos_cmd_t in_cmd,
	output logic     out_valid,
	output mix_t     out_mix
);

	logic                               valid_s3;
	logic [WHEEL_COUNT-1:0][PROD_W-1:0] prod_s3;
	logic [WHEEL_COUNT-1:0]             sneg_s3;
	logic [SPD_W-1:0]                   corr_s3;

	logic                               valid_s4;
	logic [WHEEL_COUNT-1:0][MAG_W-1:0]  mag_s4;
	logic [WHEEL_COUNT-1:0]             fwd_s4;
	logic [WHEEL_COUNT-1:0]             rev_s4;

	logic [MAG_W-1:0]                   largest_d;

	// multiply cosine by speed magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			out_valid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			prod_s3[w] <= PROD_W'(in_cmd.cmag[w]) * PROD_W'(in_cmd.spd_mag);
			sneg_s3[w] <= in_cmd.cneg[w] ^ in_cmd.spd_neg;
		end
		corr_s3 <= in_cmd.corr;
	end

	// round to 8 fraction bits, apply sign, add correction
	always_ff @(posedge clk) begin
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			logic [PROD_W:0]          rnd;
			logic signed [VAL_W-1:0]  term;
			logic signed [VAL_W-1:0]  val;
			rnd  = ({1'b0, prod_s3[w]} + (PROD_W+1)'(PROD_RND)) >> PROD_SH;
			term = VAL_W'(rnd);
			if (sneg_s3[w]) term = -term;
			val = term + $signed({{(VAL_W-SPD_W-8){corr_s3[SPD_W-1]}}, corr_s3, 8'b0});
			mag_s4[w] <= val[VAL_W-1] ? MAG_W'(-val) : MAG_W'(val);
			fwd_s4[w] <= !val[VAL_W-1] && (val != '0);
			rev_s4[w] <= val[VAL_W-1];
		end
	end

	// find the largest magnitude
	always_comb begin
		largest_d = '0;
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			if (mag_s4[w] > largest_d) largest_d = mag_s4[w];
		end
	end

	always_ff @(posedge clk) begin
		out_mix.mag     <= mag_s4;
		out_mix.fwd     <= fwd_s4;
		out_mix.rev     <= rev_s4;
		out_mix.largest <= largest_d;
		out_mix.scale   <= largest_d > MAG_W'(DUTY_LIMIT);
	end

endmodule

// File: sv/omw_divider.sv
module omw_divider
	import omw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  div_in_t in_div,
	output logic    out_valid,
	output res_t    out_res
);

	// one quotient bit per stage, quotient is known to stay below 256
	logic                    v_s   [0:DUTY_W];
	logic [NUM_W-1:0]        rem_s [0:DUTY_W];
	logic [DUTY_W-1:0]       q_s   [0:DUTY_W];
	logic [DEN_W-1:0]        den_s [0:DUTY_W];
	div_tag_t                tag_s [0:DUTY_W];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = in_div.num;
	assign q_s[0]   = '0;
	assign den_s[0] = in_div.den;
	assign tag_s[0] = in_div.tag;

	for (genvar j = 0; j < DUTY_W; j++) begin : g_stage
		localparam int K = DUTY_W - 1 - j;
		logic [NUM_W-1:0] sub;
		logic             ge;

		always_comb begin
			sub = NUM_W'(den_s[j]) << K;
			ge  = rem_s[j] >= sub;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? rem_s[j] - sub : rem_s[j];
			q_s[j+1]   <= q_s[j] | (DUTY_W'(ge) << K);
			den_s[j+1] <= den_s[j];
			tag_s[j+1] <= tag_s[j];
		end
	end

	// pick scaled or direct duty
	always_comb begin
		out_valid    = v_s[DUTY_W];
		out_res.idx  = tag_s[DUTY_W].idx;
		out_res.duty = tag_s[DUTY_W].scale ? q_s[DUTY_W] : tag_s[DUTY_W].direct;
		out_res.fwd  = tag_s[DUTY_W].fwd;
		out_res.rev  = tag_s[DUTY_W].rev;
		out_res.last = tag_s[DUTY_W].last;
	end

endmodule

// File: sv/omni_wheel_motor_mixer.sv
// Channel   | Handshake                 | Payload
// command   | start, busy               | speed, heading, correction
// config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
// result    | strobe                    | wheel_index, duty, drive_forward,
//           |                           | drive_reverse, last_wheel
//
// busy rises after an accept and holds off the next command until gap_q has
// counted down, since the single result port emits one wheel per cycle. The
// results pass through omw_angle_cos, omw_wheel_calc, the hold and divider
// input registers and omw_divider, then come out one per cycle.
// Duty scaling runs through an 8-stage divider, one quotient bit per stage.
// Reset clears valid bits and loads the default wheel angles; no clearing pass.
// The result side never stalls; cfg_ready is always high.
module omni_wheel_motor_mixer
	import omw_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [SPD_W-1:0] speed,
	input  logic [ANGLE_W-1:0]      heading,
	input  logic signed [SPD_W-1:0] correction,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_W-1:0]        cfg_index,
	input  logic [ANGLE_W-1:0]      cfg_data,
	output logic                    strobe,
	output logic [WI_W-1:0]         wheel_index,
	output logic [DUTY_W-1:0]       duty,
	output logic                    drive_forward,
	output logic                    drive_reverse,
	output logic                    last_wheel
);

	logic [NUM_ANGLE_REGS-1:0][ANGLE_W-1:0] angle_q;
	logic [CNT_W-1:0] gap_q;
	logic             accept;

	logic     cos_valid;
	cos_cmd_t cos_cmd;
	logic     mix_valid;
	mix_t     mix;

	mix_t             hold_q;
	logic             active_q;
	logic [CNT_W-1:0] cnt_q;

	logic    div_valid_q;
	div_in_t div_q;
	logic    res_valid;
	res_t    res;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign busy      = gap_q != '0;

	// write wheel angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q[0] <= ANGLE_RST_0;
			angle_q[1] <= ANGLE_RST_1;
			angle_q[2] <= ANGLE_RST_2;
			angle_q[3] <= ANGLE_RST_3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WHEEL_ANGLE_0: angle_q[0] <= cfg_data;
				CFG_WHEEL_ANGLE_1: angle_q[1] <= cfg_data;
				CFG_WHEEL_ANGLE_2: angle_q[2] <= cfg_data;
				CFG_WHEEL_ANGLE_3: angle_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// space commands so that the wheel results of one command do not overlap the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= CNT_W'(WHEEL_COUNT - 1);
		end else if (gap_q != '0) begin
			gap_q <= gap_q - 1'b1;
		end
	end

	omw_angle_cos u_angle_cos (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.speed      (speed),
		.heading    (heading),
		.correction (correction),
		.angle      (angle_q[WHEEL_COUNT-1:0]),
		.out_valid  (cos_valid),
		.out_cmd    (cos_cmd)
	);

	omw_wheel_calc u_wheel_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cos_valid),
		.in_cmd    (cos_cmd),
		.out_valid (mix_valid),
		.out_mix   (mix)
	);

	// hold one command and walk through its wheels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (mix_valid) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			if (cnt_q == CNT_W'(WHEEL_COUNT - 1)) begin
				active_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mix_valid) begin
			hold_q <= mix;
		end
	end

	// form dividend, divisor and unscaled duty for the current wheel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_valid_q <= 1'b0;
		end else begin
			div_valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		logic [MAG_W-1:0] m;
		m = hold_q.mag[cnt_q];
		div_q.num        <= NUM_W'(m) * NUM_W'(DUTY_SCALE) + NUM_W'(hold_q.largest);
		div_q.den        <= {hold_q.largest, 1'b0};
		div_q.tag.direct <= DUTY_W'(((MAG_W+1)'(m) + (MAG_W+1)'(128)) >> 8);
		div_q.tag.scale  <= hold_q.scale;
		div_q.tag.fwd    <= hold_q.fwd[cnt_q];
		div_q.tag.rev    <= hold_q.rev[cnt_q];
		div_q.tag.idx    <= WI_W'(cnt_q);
		div_q.tag.last   <= cnt_q == CNT_W'(WHEEL_COUNT - 1);
	end

	omw_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid_q),
		.in_div    (div_q),
		.out_valid (res_valid),
		.out_res   (res)
	);

	assign strobe        = res_valid;
	assign wheel_index   = res.idx;
	assign duty          = res.duty;
	assign drive_forward = res.fwd;
	assign drive_reverse = res.rev;
	assign last_wheel    = res.last;

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_wheel |-> wheel_index == WI_W'(WHEEL_COUNT - 1))
		else $error("last wheel flag on wrong wheel index");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted command");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(drive_forward && drive_reverse))
		else $error("both direction bits set");

	a_wheel_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_wheel |=> strobe && wheel_index == $past(wheel_index) + 1'b1)
		else $error("wheel results of a command not back to back");

endmodule
